// File: hdl/sinusoid_bank_synthesizer_core_macros.svh
// ============================================================================
// Sinusoid bank synthesizer assertion macros
// Shared assertion forms used by the synthesizer RTL.
// ============================================================================
`ifndef SINUSOID_BANK_SYNTHESIZER_CORE_MACROS_SVH
`define SINUSOID_BANK_SYNTHESIZER_CORE_MACROS_SVH

// A condition that holds at every clock edge out of reset.
`define SBS_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition that implies another in the next cycle.
`define SBS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/sbs_pkg.sv
// ============================================================================
// Sinusoid bank synthesizer package
// Types, codes and the quarter-wave sine table generator.
// ============================================================================
`timescale 1ns / 1ps

package sbs_pkg;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam int SAMPLE_W = 21;

    typedef enum logic [1:0] {
        CFG_ACTIVE_COUNT   = 2'd0,
        CFG_SAMPLE_SPACING = 2'd1,
        CFG_FRAME_ADVANCE  = 2'd2
    } t_cfg_index;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_INVALID  = 2'd1,
        STATUS_NO_COMPS = 2'd2
    } t_status;

    typedef enum logic {
        MODE_LOAD  = 1'b0,
        MODE_FRAME = 1'b1
    } t_mode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_RUN,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        logic clear;
        logic issue;
    } t_mac_ctl;

    // Entry idx of the quarter-wave table, round(32767*sin(pi/2*idx/2^bits)).
    function automatic logic [14:0] sine_entry(input int unsigned idx, input int unsigned bits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] v;
        x = (64'(idx) * HALF_PI_Q30) >> bits;
        x2 = (x * x) >> 30;
        term = x;
        sum = x;
        for (int unsigned n = 1; n <= 7; n++) begin
            term = (term * x2) >> 30;
            term = term / 64'((2 * n) * (2 * n + 1));
            if (n[0]) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        v = (sum * 64'd32767 + 64'd536870912) >> 30;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return v[14:0];
    endfunction

endpackage

// File: hdl/sbs_mac.sv
// ============================================================================
// Sinusoid bank multiply-accumulate unit
// Component memory and a short pipeline that adds one component per cycle.
// ============================================================================
`timescale 1ns / 1ps

module sbs_mac import sbs_pkg::*; #(
    parameter int NUM_COMPONENTS  = 16,
    parameter int SINE_TABLE_BITS = 10,
    parameter int IW              = 4,
    parameter int ACC_W           = 37
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_we,
    input  logic [IW-1:0]           i_waddr,
    input  logic signed [15:0]      i_wsa,
    input  logic signed [15:0]      i_wca,
    input  logic [31:0]             i_wf,
    input  t_mac_ctl                i_ctl,
    input  logic [IW-1:0]           i_raddr,
    input  logic [31:0]             i_t,
    output logic signed [ACC_W-1:0] o_acc,
    output logic                    o_busy
);

    localparam int QLEN = 1 << SINE_TABLE_BITS;
    localparam int B = SINE_TABLE_BITS;

    logic signed [15:0] r_mem_sa [NUM_COMPONENTS];
    logic signed [15:0] r_mem_ca [NUM_COMPONENTS];
    logic [31:0]        r_mem_f  [NUM_COMPONENTS];

    logic [14:0] w_tab [QLEN+1];

    logic                    r_v0, r_v1, r_v2;
    logic signed [15:0]      r_sa0, r_ca0, r_sa1, r_ca1;
    logic [31:0]             r_f0;
    logic [31:0]             r_ph;
    logic signed [31:0]      r_p1, r_p2;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [15:0]      w_trig [2];

    for (genvar g = 0; g <= QLEN; g++) begin : g_tab
        assign w_tab[g] = sine_entry(g, B);
    end

    always_comb begin
        logic [1:0] quad;
        logic [B:0] qi;
        for (int j = 0; j < 2; j++) begin
            quad = r_ph[31:30] + 2'(j);
            qi = {1'b0, r_ph[29 -: B]};
            if (quad[0]) begin
                qi = (B+1)'(QLEN) - qi;
            end
            w_trig[j] = quad[1] ? -$signed({1'b0, w_tab[qi]}) : $signed({1'b0, w_tab[qi]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem_sa[i_waddr] <= i_wsa;
            r_mem_ca[i_waddr] <= i_wca;
            r_mem_f[i_waddr]  <= i_wf;
        end
        r_sa0 <= r_mem_sa[i_raddr];
        r_ca0 <= r_mem_ca[i_raddr];
        r_f0  <= r_mem_f[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        r_ph  <= i_t * r_f0;
        r_sa1 <= r_sa0;
        r_ca1 <= r_ca0;
        r_p1  <= r_sa1 * w_trig[0];
        r_p2  <= r_ca1 * w_trig[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0  <= 1'b0;
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_acc <= '0;
        end else begin
            r_v0 <= i_ctl.issue;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            if (i_ctl.clear) begin
                r_acc <= '0;
            end else if (r_v2) begin
                r_acc <= r_acc + ACC_W'(r_p1) + ACC_W'(r_p2);
            end
        end
    end

    assign o_acc  = r_acc;
    assign o_busy = r_v0 | r_v1 | r_v2;

endmodule

// File: hdl/sinusoid_bank_synthesizer_core.sv
// ============================================================================
// Sinusoid bank synthesizer core
// Sums sine and cosine components of a loaded table into frames of samples.
// ============================================================================
//  Channel   Direction  Handshake                  Word
//  input     in         i_in_valid / o_in_stall    load or frame request
//  output    out        o_out_valid / i_out_stall  one sample with last, status
//  config    in         i_cfg_we                   one register write
//
// A load or a rejected frame gives its word in the cycle after it is taken.
// The input stays stalled while a word waits in the output register.
// Each sample accumulates n components, n being the active component count
// (at most NUM_COMPONENTS), in the one-component-per-cycle accumulate pipeline.
// Reset is synchronous; output stalls hold the sequencer before each sample.
`timescale 1ns / 1ps

module sinusoid_bank_synthesizer_core import sbs_pkg::*; #(
    parameter int NUM_COMPONENTS  = 16,
    parameter int MAX_POINTS      = 64,
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_mode,
    input  logic [3:0]                 i_entry_index,
    input  logic signed [15:0]         i_sine_amp,
    input  logic signed [15:0]         i_cosine_amp,
    input  logic [31:0]                i_freq_step,
    input  logic [6:0]                 i_point_count,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic signed [SAMPLE_W-1:0] o_sample,
    output logic                       o_last,
    output logic [1:0]                 o_status,
    input  logic                       i_cfg_we,
    input  logic [1:0]                 i_cfg_index,
    input  logic [15:0]                i_cfg_data
);

    `include "sinusoid_bank_synthesizer_core_macros.svh"

    localparam int IW    = (NUM_COMPONENTS > 1) ? $clog2(NUM_COMPONENTS) : 1;
    localparam int CW    = $clog2(NUM_COMPONENTS + 1) + 1;
    localparam int ACC_W = 33 + $clog2(NUM_COMPONENTS + 1);

    t_state r_state, n_state;

    logic [4:0]  r_active;
    logic [15:0] r_spacing;
    logic [15:0] r_advance;
    logic [31:0] r_time;
    logic [31:0] r_t;
    logic [CW-1:0] r_n;
    logic [CW-1:0] r_i;
    logic [6:0]  r_count;
    logic [6:0]  r_k;

    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic                       r_last;
    logic [1:0]                 r_status;

    t_mac_ctl                w_ctl;
    logic signed [ACC_W-1:0] w_acc;
    logic                    w_busy;
    logic                    w_in_acc;
    logic                    w_out_free;
    logic                    w_load_smp;
    logic                    w_final;
    logic                    w_we;
    logic signed [ACC_W:0]   w_rnd;
    logic signed [ACC_W-15:0] w_shift;
    logic signed [SAMPLE_W-1:0] w_sat;
    logic                    w_bad_cnt;

    sbs_mac #(
        .NUM_COMPONENTS (NUM_COMPONENTS),
        .SINE_TABLE_BITS(SINE_TABLE_BITS),
        .IW             (IW),
        .ACC_W          (ACC_W)
    ) u_mac (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_we   (w_we),
        .i_waddr(IW'(i_entry_index)),
        .i_wsa  (i_sine_amp),
        .i_wca  (i_cosine_amp),
        .i_wf   (i_freq_step),
        .i_ctl  (w_ctl),
        .i_raddr(r_i[IW-1:0]),
        .i_t    (r_t),
        .o_acc  (w_acc),
        .o_busy (w_busy)
    );

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_we       = w_in_acc && (i_mode == MODE_LOAD)
                        && (int'(i_entry_index) < NUM_COMPONENTS);
    assign w_bad_cnt  = (i_point_count == 7'd0) || (int'(i_point_count) > MAX_POINTS);
    assign w_final    = (r_k + 7'd1 == r_count);

    always_comb begin
        w_rnd   = (ACC_W+1)'(w_acc) + (ACC_W+1)'(16384);
        w_shift = w_rnd[ACC_W:15];
        if (w_shift > (ACC_W-14)'(1048575)) begin
            w_sat = SAMPLE_W'(1048575);
        end else if (w_shift < -(ACC_W-14)'(1048576)) begin
            w_sat = SAMPLE_W'(-1048576);
        end else begin
            w_sat = w_shift[SAMPLE_W-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc && (i_mode == MODE_FRAME) && !w_bad_cnt && (r_active != 5'd0)) begin
                    n_state = ST_CLEAR;
                end
            end
            ST_CLEAR: begin
                n_state = ST_RUN;
            end
            ST_RUN: begin
                if (r_i == r_n - CW'(1)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!w_busy && w_out_free) begin
                    n_state = w_final ? ST_IDLE : ST_CLEAR;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        w_ctl.clear = (r_state == ST_CLEAR);
        w_ctl.issue = (r_state == ST_RUN);
        w_load_smp  = (r_state == ST_DRAIN) && !w_busy && w_out_free;
        o_in_stall  = (r_state != ST_IDLE) || r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_active    <= 5'd0;
            r_spacing   <= 16'd500;
            r_advance   <= 16'd1;
            r_time      <= 32'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ACTIVE_COUNT:   r_active  <= i_cfg_data[4:0];
                    CFG_SAMPLE_SPACING: r_spacing <= i_cfg_data;
                    CFG_FRAME_ADVANCE:  r_advance <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (w_load_smp && w_final) begin
                r_time <= r_time + 32'(r_advance);
            end
            if (w_in_acc) begin
                r_out_valid <= (i_mode == MODE_LOAD) || w_bad_cnt || (r_active == 5'd0);
            end else if (w_load_smp) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_sample <= '0;
            r_last   <= 1'b1;
            if (i_mode == MODE_LOAD) begin
                r_status <= STATUS_OK;
            end else if (w_bad_cnt) begin
                r_status <= STATUS_INVALID;
            end else begin
                r_status <= STATUS_NO_COMPS;
            end
            r_t     <= r_time;
            r_k     <= 7'd0;
            r_count <= i_point_count;
            if (int'(r_active) > NUM_COMPONENTS) begin
                r_n <= CW'(NUM_COMPONENTS);
            end else begin
                r_n <= CW'(r_active);
            end
        end else if (w_load_smp) begin
            r_sample <= w_sat;
            r_last   <= w_final;
            r_status <= STATUS_OK;
            r_k      <= r_k + 7'd1;
            r_t      <= r_t + 32'(r_spacing);
        end
        if (r_state == ST_CLEAR) begin
            r_i <= '0;
        end else if (r_state == ST_RUN) begin
            r_i <= r_i + CW'(1);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_sample    = r_sample;
    assign o_last      = r_last;
    assign o_status    = r_status;

    `SBS_ASSERT_ALWAYS(a_busy_stalls, i_clk, i_rst_n, (r_state == ST_IDLE) || o_in_stall, "input taken while busy")
    `SBS_ASSERT_ALWAYS(a_issue_range, i_clk, i_rst_n, (r_state != ST_RUN) || (r_i < r_n), "component index beyond count")
    `SBS_ASSERT_NEXT(a_time_hold, i_clk, i_rst_n, !(w_load_smp && w_final), $stable(r_time), "time moved outside frame end")

endmodule

// File: tb/sbs_checker.sv
// ============================================================================
// Sinusoid bank synthesizer checker
// Watches the input, output and register ports of the synthesizer, keeps its
// own copy of the component table, time and registers, predicts every output
// word of each accepted input word and compares them in order.
// ============================================================================
`timescale 1ns / 1ps

module sbs_checker import sbs_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_stall,
    input  logic                       i_mode,
    input  logic [3:0]                 i_entry_index,
    input  logic signed [15:0]         i_sine_amp,
    input  logic signed [15:0]         i_cosine_amp,
    input  logic [31:0]                i_freq_step,
    input  logic [6:0]                 i_point_count,
    input  logic                       i_out_valid,
    input  logic                       i_out_stall,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic                       i_last,
    input  logic [1:0]                 i_status,
    input  logic                       i_cfg_we,
    input  logic [1:0]                 i_cfg_index,
    input  logic [15:0]                i_cfg_data,
    output int                         o_errors,
    output int                         o_pending
);

    localparam int COMPS = 16;
    localparam int MAX_PTS = 64;
    localparam int QUARTER = 1024;

    typedef struct {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
        t_status                    status;
    } t_word;

    t_word             expected_words[$];
    int                quarter_wave[QUARTER + 1];
    logic signed [15:0] sin_amps[COMPS];
    logic signed [15:0] cos_amps[COMPS];
    logic [31:0]       freqs[COMPS];
    logic [31:0]       clock_ticks;
    logic [4:0]        active_comps;
    logic [15:0]       spacing;
    logic [15:0]       advance;

    initial begin
        bit [63:0] x;
        bit [63:0] x2;
        bit [63:0] term;
        bit [63:0] sum;
        bit [63:0] v;
        for (int i = 0; i <= QUARTER; i++) begin
            x = (64'(i) * 64'd1686629713) >> 10;
            x2 = (x * x) >> 30;
            term = x;
            sum = x;
            for (int n = 1; n <= 7; n++) begin
                term = (term * x2) >> 30;
                term = term / 64'((2 * n) * (2 * n + 1));
                if (n % 2 == 1) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
            v = (sum * 64'd32767 + 64'd536870912) >> 30;
            if (v > 64'd32767) begin
                v = 64'd32767;
            end
            quarter_wave[i] = int'(v);
        end
        o_errors = 0;
        o_pending = 0;
    end

    function automatic longint sine_at(logic [31:0] ph);
        int idx;
        idx = int'(ph[29:20]);
        if (ph[30]) begin
            idx = QUARTER - idx;
        end
        return ph[31] ? -longint'(quarter_wave[idx]) : longint'(quarter_wave[idx]);
    endfunction

    task automatic push_word(logic signed [SAMPLE_W-1:0] s, logic l, t_status st);
        t_word w;
        w.sample = s;
        w.last = l;
        w.status = st;
        expected_words.push_back(w);
    endtask

    task automatic predict_frame(int points);
        int          n;
        logic [31:0] t;
        logic [31:0] ph;
        longint      acc;
        longint      s;
        n = (active_comps > COMPS) ? COMPS : int'(active_comps);
        for (int k = 0; k < points; k++) begin
            t = clock_ticks + 32'(k) * 32'(spacing);
            acc = 0;
            for (int i = 0; i < n; i++) begin
                ph = t * freqs[i];
                acc += longint'(sin_amps[i]) * sine_at(ph);
                acc += longint'(cos_amps[i]) * sine_at(ph + 32'h4000_0000);
            end
            s = (acc + 64'sd16384) >>> 15;
            if (s > 1048575) begin
                s = 1048575;
            end
            if (s < -1048576) begin
                s = -1048576;
            end
            push_word(SAMPLE_W'(s), k == points - 1, STATUS_OK);
        end
        clock_ticks = clock_ticks + 32'(advance);
    endtask

    always @(posedge i_clk) begin
        t_word w;
        if (!i_rst_n) begin
            clock_ticks = '0;
            active_comps = '0;
            spacing = 16'd500;
            advance = 16'd1;
            expected_words.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_ACTIVE_COUNT: active_comps = i_cfg_data[4:0];
                    CFG_SAMPLE_SPACING: spacing = i_cfg_data;
                    CFG_FRAME_ADVANCE: advance = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_words.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10) begin
                        $display("unexpected word: sample %0d last %0d status %0d",
                                 i_sample, i_last, i_status);
                    end
                end else begin
                    w = expected_words.pop_front();
                    if (i_sample !== w.sample || i_last !== w.last || i_status !== w.status) begin
                        o_errors++;
                        if (o_errors <= 10) begin
                            $display("mismatch: expected %0d/%0d/%0d got %0d/%0d/%0d",
                                     w.sample, w.last, w.status, i_sample, i_last, i_status);
                        end
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (t_mode'(i_mode) == MODE_LOAD) begin
                    sin_amps[i_entry_index] = i_sine_amp;
                    cos_amps[i_entry_index] = i_cosine_amp;
                    freqs[i_entry_index] = i_freq_step;
                    push_word('0, 1'b1, STATUS_OK);
                end else if (i_point_count == 0 || i_point_count > MAX_PTS) begin
                    push_word('0, 1'b1, STATUS_INVALID);
                end else if (active_comps == 0) begin
                    push_word('0, 1'b1, STATUS_NO_COMPS);
                end else begin
                    predict_frame(int'(i_point_count));
                end
            end
        end
        o_pending = expected_words.size();
    end

endmodule

// File: tb/tb.sv
// ============================================================================
// Sinusoid bank synthesizer testbench
// Loads the component table, runs directed frames at the register extremes
// and then random load and frame words over several register settings, with
// random idling on both channels and one long output hold-off.
// ============================================================================
`timescale 1ns / 1ps

module tb;
    import sbs_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES    = 400;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_stall;
    logic                       i_mode = 1'b0;
    logic [3:0]                 i_entry_index = '0;
    logic signed [15:0]         i_sine_amp = '0;
    logic signed [15:0]         i_cosine_amp = '0;
    logic [31:0]                i_freq_step = '0;
    logic [6:0]                 i_point_count = '0;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    logic signed [SAMPLE_W-1:0] o_sample;
    logic                       o_last;
    logic [1:0]                 o_status;
    logic                       i_cfg_we = 1'b0;
    logic [1:0]                 i_cfg_index = '0;
    logic [15:0]                i_cfg_data = '0;

    int errors;
    int pending;
    int idle_cycles = 0;
    int hold_left = 0;
    bit hold_req = 1'b0;
    bit hold_seen = 1'b0;
    bit calm = 1'b0;

    always #5 i_clk = ~i_clk;

    sinusoid_bank_synthesizer_core u_top (.*);

    sbs_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_stall(o_in_stall),
        .i_mode(i_mode), .i_entry_index(i_entry_index),
        .i_sine_amp(i_sine_amp), .i_cosine_amp(i_cosine_amp),
        .i_freq_step(i_freq_step), .i_point_count(i_point_count),
        .i_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .i_sample(o_sample), .i_last(o_last), .i_status(o_status),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        hold_seen <= hold_req;
        if (hold_req && !hold_seen) begin
            i_out_stall <= 1'b1;
            hold_left <= HOLD_CYCLES - 1;
        end else if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else begin
            i_out_stall <= !calm && ($urandom_range(99) < 38);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    task automatic send_word(t_mode m, logic [3:0] idx, logic [15:0] sa, logic [15:0] ca,
                             logic [31:0] freq, logic [6:0] points);
        bit stalled;
        if (!calm && $urandom_range(99) < 38) begin
            i_in_valid <= 1'b0;
            do begin
                @(posedge i_clk);
            end while ($urandom_range(99) < 38);
        end
        i_in_valid <= 1'b1;
        i_mode <= m;
        i_entry_index <= idx;
        i_sine_amp <= sa;
        i_cosine_amp <= ca;
        i_freq_step <= freq;
        i_point_count <= points;
        do begin
            @(negedge i_clk);
            stalled = o_in_stall;
            @(posedge i_clk);
        end while (stalled);
    endtask

    task automatic load_random();
        send_word(MODE_LOAD, 4'($urandom), 16'($urandom), 16'($urandom), $urandom, 7'($urandom));
    endtask

    task automatic frame_random();
        int r;
        logic [6:0] points;
        r = $urandom_range(99);
        if (r < 3) begin
            points = 7'd0;
        end else if (r < 6) begin
            points = 7'($urandom_range(127, 65));
        end else if (r < 92) begin
            points = 7'($urandom_range(8, 1));
        end else begin
            points = 7'($urandom_range(64, 9));
        end
        send_word(MODE_FRAME, 4'($urandom), 16'($urandom), 16'($urandom), $urandom, points);
    endtask

    task automatic settle();
        bit busy;
        i_in_valid <= 1'b0;
        do begin
            @(negedge i_clk);
            busy = pending != 0;
            @(posedge i_clk);
        end while (busy);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic set_registers(logic [15:0] comps, logic [15:0] gap, logic [15:0] step);
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_ACTIVE_COUNT;
        i_cfg_data <= comps;
        @(posedge i_clk);
        i_cfg_index <= CFG_SAMPLE_SPACING;
        i_cfg_data <= gap;
        @(posedge i_clk);
        i_cfg_index <= CFG_FRAME_ADVANCE;
        i_cfg_data <= step;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_word(MODE_FRAME, 4'd0, 16'd0, 16'd0, 32'd0, 7'd4);
        send_word(MODE_FRAME, 4'd0, 16'd0, 16'd0, 32'd0, 7'd0);
        send_word(MODE_FRAME, 4'd0, 16'd0, 16'd0, 32'd0, 7'd65);
        send_word(MODE_FRAME, 4'd0, 16'd0, 16'd0, 32'd0, 7'd127);
        for (int i = 0; i < 16; i++) begin
            case (i % 4)
                0: send_word(MODE_LOAD, 4'(i), 16'h7FFF, 16'h8000, 32'hFFFF_FFFF, 7'd0);
                1: send_word(MODE_LOAD, 4'(i), 16'h8000, 16'h7FFF, 32'd0, 7'h7F);
                default: send_word(MODE_LOAD, 4'(i), 16'($urandom), 16'($urandom),
                                   $urandom, 7'($urandom));
            endcase
        end
        settle();
        set_registers(16'd16, 16'hFFFF, 16'hFFFF);
        send_word(MODE_FRAME, 4'd0, 16'd0, 16'd0, 32'd0, 7'd64);
        send_word(MODE_FRAME, 4'd0, 16'd0, 16'd0, 32'd0, 7'd1);
        settle();

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: set_registers(16'd31, 16'hFFFF, 16'hFFFF);
                1: set_registers(16'd16, 16'($urandom), 16'($urandom));
                2: set_registers(16'd1, 16'd0, 16'd0);
                3: set_registers(16'($urandom_range(16, 1)), 16'($urandom), 16'($urandom));
                4: set_registers(16'hFFE0, 16'($urandom), 16'($urandom));
                default: set_registers(16'($urandom), 16'($urandom), 16'($urandom));
            endcase
            calm = (phase == 3);
            if (phase == 1) begin
                hold_req = 1'b1;
            end
            for (int n = 0; n < 55; n++) begin
                if ($urandom_range(99) < 25) begin
                    load_random();
                end else begin
                    frame_random();
                end
            end
            settle();
        end

        if (errors == 0 && pending == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
